// File: rtl/mfnp_pkg.sv
// types and constants for the midi file note parser
// no dependencies; imported by midi_file_note_parser
package mfnp_pkg;

  localparam int VLQ_WIDTH        = 28;
  localparam int TABLE_ADDR_WIDTH = 11;
  localparam int TABLE_DEPTH      = 2048;

  localparam logic [3:0] MAGIC_LEN  = 4'd4;
  localparam logic [3:0] HDR_LAST   = 4'd13;
  localparam logic [3:0] TRK_LAST   = 4'd7;
  localparam logic [7:0] META_STATUS = 8'hFF;

  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;

  localparam logic [1:0] KIND_DIVISION = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd2;
  localparam logic [1:0] KIND_BAD_HDR  = 2'd3;

  typedef enum logic [3:0] {
    PH_HDR       = 4'd0,
    PH_HDR_BAD   = 4'd1,
    PH_TRK       = 4'd2,
    PH_DELTA     = 4'd3,
    PH_STATUS    = 4'd4,
    PH_META_TYPE = 4'd5,
    PH_META_LEN  = 4'd6,
    PH_META_SKIP = 4'd7,
    PH_DATA1     = 4'd8,
    PH_DATA2     = 4'd9,
    PH_DEAD      = 4'd10
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [6:0]  velocity;
    logic [31:0] tick_time;
    logic [31:0] duration;
    logic [7:0]  division;
  } result_t;

  // "MThd"
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h4D;
      2'd1:    m = 8'h54;
      2'd2:    m = 8'h68;
      default: m = 8'h64;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/midi_file_note_parser.sv
// midi file note parser top level: byte decoder, note start memory, output skid
// depends on mfnp_pkg
//
// Takes a standard MIDI file one byte per beat on the byte channel and gives
// note events on the event channel. The 14-byte file header is checked for
// the "MThd" magic; its last byte comes out as a division event, or a bad
// header event if the magic is wrong, after which bytes are ignored until
// file_start marks the first byte of a new file. Track headers are skipped,
// delta times build an absolute tick time that restarts in every track, meta
// events are skipped by length and a zero-length meta event ends the track.
// Note-on (nonzero velocity) and note-off events come out with their tick
// time; a note-off also carries the ticks since the last note-on of the same
// channel and key, read from a 2048-entry start time memory. Running status
// is not supported. Rate: one byte is taken every cycle while byte_stall is
// low; each byte is decoded in one pass and its event, if any, goes into the
// result register, or the skid register while the output is stalled. The
// memory has one write and one registered read port: the read is issued on
// the key byte, so the velocity byte finds the start time ready. A two-entry
// output stage (result register plus skid register) lets bytes keep flowing
// while one event waits; byte_stall rises only when both hold events or
// while a clearing pass after reset writes zero to every entry, one a cycle.
module midi_file_note_parser #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [1:0]  kind,
  output logic [3:0]  channel,
  output logic [6:0]  key,
  output logic [6:0]  velocity,
  output logic [31:0] tick_time,
  output logic [31:0] duration,
  output logic [7:0]  division
);
  import mfnp_pkg::*;

  // parser state
  phase_t                 phase, phase_next;
  logic [3:0]             byte_count, byte_count_next;
  logic [VLQ_WIDTH-1:0]   vlq_accumulator, vlq_accumulator_next;
  logic [TIME_WIDTH-1:0]  abs_ticks, abs_ticks_next;
  logic [3:0]             message_type, message_type_next;
  logic [3:0]             message_channel, message_channel_next;
  logic [6:0]             first_data, first_data_next;
  logic [VLQ_WIDTH-1:0]   skip_remaining, skip_remaining_next;

  // note start memory and its clearing pass
  logic [TIME_WIDTH-1:0]       note_start [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0]       start_rd;
  logic                        clearing;
  logic [TABLE_ADDR_WIDTH-1:0] clear_addr;
  logic                        mem_re, mem_we;
  logic [TABLE_ADDR_WIDTH-1:0] mem_raddr, mem_waddr;
  logic [TIME_WIDTH-1:0]       mem_wdata;
  logic                        note_we;

  // output stage
  result_t res, out_res, skid_res;
  logic    res_valid, out_valid, skid_valid;

  logic                  accept;
  phase_t                ph_eff;
  logic [3:0]            cnt_eff;
  logic [VLQ_WIDTH-1:0]  vlq_new;
  logic [VLQ_WIDTH-1:0]  skip_dec;
  logic                  hdr_bad;
  logic                  is_note_off;
  logic [TIME_WIDTH-1:0] dur_full;

  // bytes stop only while memory clears or both output entries are full
  assign byte_stall = clearing | skid_valid;
  assign accept     = byte_valid & ~byte_stall;

  // file_start restarts the header check with this byte as header byte 0
  assign ph_eff  = file_start ? PH_HDR : phase;
  assign cnt_eff = file_start ? 4'd0 : byte_count;

  // base 128 quantity, kept to 28 bits
  assign vlq_new  = {vlq_accumulator[VLQ_WIDTH-8:0], data_byte[6:0]};
  assign skip_dec = skip_remaining - VLQ_WIDTH'(1);

  assign hdr_bad = (ph_eff == PH_HDR_BAD) ||
                   ((cnt_eff < MAGIC_LEN) && (data_byte != magic_byte(cnt_eff[1:0])));

  // velocity zero note-on counts as note-off
  assign is_note_off = (message_type == TYPE_NOTE_OFF) ||
                       ((message_type == TYPE_NOTE_ON) && (data_byte[6:0] == 7'd0));
  assign dur_full    = abs_ticks - start_rd;

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    vlq_accumulator_next = vlq_accumulator;
    abs_ticks_next       = abs_ticks;
    message_type_next    = message_type;
    message_channel_next = message_channel;
    first_data_next      = first_data;
    skip_remaining_next  = skip_remaining;
    res                  = '0;
    res_valid            = 1'b0;
    mem_re               = 1'b0;
    mem_raddr            = {message_channel, data_byte[6:0]};
    note_we              = 1'b0;

    if (accept) begin
      phase_next      = ph_eff;
      byte_count_next = cnt_eff;
      unique case (ph_eff)
        PH_HDR, PH_HDR_BAD: begin
          if (cnt_eff >= HDR_LAST) begin
            byte_count_next = 4'd0;
            res_valid       = 1'b1;
            if (hdr_bad) begin
              phase_next = PH_DEAD;
              res.kind   = KIND_BAD_HDR;
            end else begin
              phase_next   = PH_TRK;
              res.kind     = KIND_DIVISION;
              res.division = data_byte;
            end
          end else begin
            phase_next      = hdr_bad ? PH_HDR_BAD : PH_HDR;
            byte_count_next = cnt_eff + 4'd1;
          end
        end
        PH_TRK: begin
          if (cnt_eff >= TRK_LAST) begin
            byte_count_next      = 4'd0;
            abs_ticks_next       = '0;
            vlq_accumulator_next = '0;
            phase_next           = PH_DELTA;
          end else begin
            byte_count_next = cnt_eff + 4'd1;
          end
        end
        PH_DELTA: begin
          if (!data_byte[7]) begin
            abs_ticks_next       = abs_ticks + TIME_WIDTH'(vlq_new);
            vlq_accumulator_next = '0;
            phase_next           = PH_STATUS;
          end else begin
            vlq_accumulator_next = vlq_new;
          end
        end
        PH_STATUS: begin
          if (data_byte == META_STATUS) begin
            phase_next = PH_META_TYPE;
          end else begin
            message_type_next    = data_byte[7:4];
            message_channel_next = data_byte[3:0];
            phase_next           = PH_DATA1;
          end
        end
        PH_META_TYPE: begin
          vlq_accumulator_next = '0;
          phase_next           = PH_META_LEN;
        end
        PH_META_LEN: begin
          if (!data_byte[7]) begin
            if (vlq_new == '0) begin
              phase_next      = PH_TRK;
              byte_count_next = 4'd0;
            end else begin
              skip_remaining_next = vlq_new;
              phase_next          = PH_META_SKIP;
            end
            vlq_accumulator_next = '0;
          end else begin
            vlq_accumulator_next = vlq_new;
          end
        end
        PH_META_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next = PH_DELTA;
          end
        end
        PH_DATA1: begin
          first_data_next = data_byte[6:0];
          // fetch the start time now so it is ready for the velocity byte
          mem_re = 1'b1;
          if (message_type == TYPE_PROGRAM || message_type == TYPE_PRESSURE) begin
            vlq_accumulator_next = '0;
            phase_next           = PH_DELTA;
          end else begin
            phase_next = PH_DATA2;
          end
        end
        PH_DATA2: begin
          vlq_accumulator_next = '0;
          phase_next           = PH_DELTA;
          res.channel          = message_channel;
          res.key              = first_data;
          res.velocity         = data_byte[6:0];
          res.tick_time        = 32'(abs_ticks);
          if (is_note_off) begin
            res_valid    = 1'b1;
            res.kind     = KIND_NOTE_OFF;
            res.duration = 32'(dur_full);
          end else if (message_type == TYPE_NOTE_ON) begin
            res_valid = 1'b1;
            res.kind  = KIND_NOTE_ON;
            note_we   = 1'b1;
          end
        end
        PH_DEAD: begin
        end
        default: begin
        end
      endcase
    end
  end

  // single write port shared by the clearing pass and note-on
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = note_we;
      mem_waddr = {message_channel, first_data};
      mem_wdata = abs_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_start[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      start_rd <= note_start[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + TABLE_ADDR_WIDTH'(1);
      if (clear_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR;
      byte_count      <= '0;
      vlq_accumulator <= '0;
      abs_ticks       <= '0;
      message_type    <= '0;
      message_channel <= '0;
      first_data      <= '0;
      skip_remaining  <= '0;
    end else begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      vlq_accumulator <= vlq_accumulator_next;
      abs_ticks       <= abs_ticks_next;
      message_type    <= message_type_next;
      message_channel <= message_channel_next;
      first_data      <= first_data_next;
      skip_remaining  <= skip_remaining_next;
    end
  end

  // output register with skid entry; skid only fills while the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !event_stall) begin
      out_valid  <= skid_valid | res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !event_stall) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

  assign event_valid = out_valid;
  assign kind        = out_res.kind;
  assign channel     = out_res.channel;
  assign key         = out_res.key;
  assign velocity    = out_res.velocity;
  assign tick_time   = out_res.tick_time;
  assign duration    = out_res.duration;
  assign division    = out_res.division;

  // no bytes are taken during the clearing pass
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> byte_stall)
    else $error("byte taken during memory clear");

  // the skid entry is never occupied without a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> event_valid)
    else $error("skid holds a beat while output is empty");

  // the skid entry only fills when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(event_valid && event_stall))
    else $error("skid filled without a stalled output");

  // clearing ends only after the last entry was written
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clear_addr) == '1)
    else $error("clearing pass ended early");

  // note-on carries no duration and no event but division carries division
  a_note_on_fields: assert property (@(posedge clk) disable iff (rst)
    (event_valid && kind == KIND_NOTE_ON) |-> (duration == '0 && division == '0))
    else $error("note-on beat with duration or division set");

endmodule

// File: test/midi_file_note_parser_checker.sv
`timescale 1ns / 100ps
// event checker for the midi file note parser: follows both channels and
// predicts every event from the accepted bytes; depends on mfnp_pkg
module midi_file_note_parser_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  input  logic        event_valid,
  input  logic        event_stall,
  input  logic [1:0]  kind,
  input  logic [3:0]  channel,
  input  logic [6:0]  key,
  input  logic [6:0]  velocity,
  input  logic [31:0] tick_time,
  input  logic [31:0] duration,
  input  logic [7:0]  division,
  output int          mismatches,
  output int          pending,
  output int          events_seen,
  output int          note_ons,
  output int          note_offs
);
  import mfnp_pkg::*;

  localparam logic [31:0] FILE_TAG = "MThd";

  // parser state as the block should hold it
  phase_t      ph;
  logic [3:0]  nbytes;
  logic [27:0] vlq;
  logic [31:0] now_ticks;
  logic [3:0]  msg_type;
  logic [3:0]  msg_chan;
  logic [6:0]  key_byte;
  logic [27:0] skip_left;
  logic [31:0] start_ticks [TABLE_DEPTH];

  result_t expected_events [$];

  // one byte through the parser; returns 1 when it yields an event
  function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                    output result_t ev);
    logic [TABLE_ADDR_WIDTH-1:0] idx;
    ev = '0;
    if (start) begin
      ph = PH_HDR;
      nbytes = '0;
    end
    case (ph)
      PH_HDR, PH_HDR_BAD: begin
        if (nbytes < MAGIC_LEN && b != FILE_TAG[8*(3-nbytes[1:0]) +: 8])
          ph = PH_HDR_BAD;
        if (nbytes >= HDR_LAST) begin
          nbytes = '0;
          if (ph == PH_HDR_BAD) begin
            ph = PH_DEAD;
            ev.kind = KIND_BAD_HDR;
          end else begin
            ph = PH_TRK;
            ev.kind = KIND_DIVISION;
            ev.division = b;
          end
          return 1;
        end
        nbytes++;
      end
      PH_TRK: begin
        if (nbytes >= TRK_LAST) begin
          nbytes = '0;
          now_ticks = '0;
          vlq = '0;
          ph = PH_DELTA;
        end else begin
          nbytes++;
        end
      end
      PH_DELTA: begin
        vlq = {vlq[20:0], b[6:0]};
        if (!b[7]) begin
          now_ticks = now_ticks + 32'(vlq);
          vlq = '0;
          ph = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b == META_STATUS) begin
          ph = PH_META_TYPE;
        end else begin
          msg_type = b[7:4];
          msg_chan = b[3:0];
          ph = PH_DATA1;
        end
      end
      PH_META_TYPE: begin
        vlq = '0;
        ph = PH_META_LEN;
      end
      PH_META_LEN: begin
        vlq = {vlq[20:0], b[6:0]};
        if (!b[7]) begin
          if (vlq == '0) begin
            // zero-length meta closes the track
            ph = PH_TRK;
            nbytes = '0;
          end else begin
            skip_left = vlq;
            ph = PH_META_SKIP;
          end
          vlq = '0;
        end
      end
      PH_META_SKIP: begin
        skip_left = skip_left - 28'd1;
        if (skip_left == '0) ph = PH_DELTA;
      end
      PH_DATA1: begin
        key_byte = b[6:0];
        if (msg_type == TYPE_PROGRAM || msg_type == TYPE_PRESSURE) begin
          vlq = '0;
          ph = PH_DELTA;
        end else begin
          ph = PH_DATA2;
        end
      end
      PH_DATA2: begin
        vlq = '0;
        ph = PH_DELTA;
        idx = {msg_chan, key_byte};
        ev.channel = msg_chan;
        ev.key = key_byte;
        ev.velocity = b[6:0];
        ev.tick_time = now_ticks;
        if (msg_type == TYPE_NOTE_OFF || (msg_type == TYPE_NOTE_ON && b[6:0] == '0)) begin
          ev.kind = KIND_NOTE_OFF;
          ev.duration = now_ticks - start_ticks[idx];
          return 1;
        end
        if (msg_type == TYPE_NOTE_ON) begin
          start_ticks[idx] = now_ticks;
          ev.kind = KIND_NOTE_ON;
          return 1;
        end
      end
      default: ;
    endcase
    return 0;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] seen_v);
    if (seen_v !== want_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want_v, seen_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (rst) begin
      ph = PH_HDR;
      nbytes = '0;
      vlq = '0;
      now_ticks = '0;
      msg_type = '0;
      msg_chan = '0;
      key_byte = '0;
      skip_left = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) start_ticks[i] = '0;
      expected_events.delete();
      mismatches = 0;
      events_seen = 0;
      note_ons = 0;
      note_offs = 0;
    end else begin
      if (event_valid && !event_stall) begin
        seen = {kind, channel, key, velocity, tick_time, duration, division};
        events_seen++;
        if (seen.kind == KIND_NOTE_ON) note_ons++;
        if (seen.kind == KIND_NOTE_OFF) note_offs++;
        if (expected_events.size() == 0) begin
          $display("%0t: event with none expected, expected nothing, got kind %0d",
                   $time, seen.kind);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          compare_field("kind", 32'(want.kind), 32'(seen.kind));
          compare_field("channel", 32'(want.channel), 32'(seen.channel));
          compare_field("key", 32'(want.key), 32'(seen.key));
          compare_field("velocity", 32'(want.velocity), 32'(seen.velocity));
          compare_field("tick_time", want.tick_time, seen.tick_time);
          compare_field("duration", want.duration, seen.duration);
          compare_field("division", 32'(want.division), 32'(seen.division));
        end
      end
      if (byte_valid && !byte_stall) begin
        if (parse_byte(data_byte, file_start, want))
          expected_events.insert(expected_events.size(), want);
      end
    end
    pending = expected_events.size();
  end

endmodule

// File: test/midi_file_note_parser_test.sv
`timescale 1ns / 100ps
// testbench top for midi_file_note_parser: builds byte streams of MIDI files
// and drives both channels; depends on mfnp_pkg and the event checker
module midi_file_note_parser_test;
  import mfnp_pkg::*;

  localparam int STALL_LIMIT = 8000;   // clearing pass and long hold fit well inside
  localparam int HOLD_CYCLES = 200;    // long receiver hold-off to fill the output stage
  localparam int TAIL_CYCLES = 16;

  // status nibbles and meta types not named in the package
  localparam logic [3:0] TYPE_KEY_PRESSURE = 4'hA;
  localparam logic [3:0] TYPE_CONTROL      = 4'hB;
  localparam logic [7:0] META_TEXT         = 8'h01;
  localparam logic [7:0] META_TEMPO        = 8'h51;
  localparam logic [7:0] META_END_TRACK    = 8'h2F;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  data_byte;
  logic        file_start;
  logic        event_valid;
  logic        event_stall;
  logic [1:0]  kind;
  logic [3:0]  channel;
  logic [6:0]  key;
  logic [6:0]  velocity;
  logic [31:0] tick_time;
  logic [31:0] duration;
  logic [7:0]  division;

  int mismatches;
  int pending;
  int events_seen;
  int note_ons;
  int note_offs;

  int send_idle;       // percent of cycles the byte side idles
  int recv_idle;       // percent of cycles the event side stalls
  int hold_req;        // bumped to ask the event side for a long hold-off
  int bytes_taken;
  int files_sent;
  int idle_cycles;

  midi_file_note_parser dut (.*);

  midi_file_note_parser_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // event side: random stalls, plus a counted hold-off on request
  initial begin
    int hold_left;
    int seen_req;
    hold_left = 0;
    seen_req = 0;
    event_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != seen_req) begin
        seen_req = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        event_stall <= 1'b1;
      end else begin
        event_stall <= ($urandom_range(0, 99) < recv_idle);
      end
    end
  end

  // watchdog: counts cycles in which neither channel moves a beat
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (event_valid && !event_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat on either channel for %0d cycles", $time, STALL_LIMIT);
        $display("midi_file_note_parser verification failed");
        $finish;
      end
    end
  end

  // one beat on the byte channel, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(0, 99) < send_idle) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    file_start <= st;
    do @(posedge clk); while (byte_stall);
    bytes_taken++;
    @(negedge clk);
  endtask

  // variable-length quantity, base 128; groups above the minimum pad with
  // leading continuation bytes, five groups reach past the 28-bit accumulator
  task automatic send_quantity(input logic [34:0] v, input int groups);
    int n;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    if (groups > n) n = groups;
    for (int i = n - 1; i >= 0; i--) send_byte({i != 0, 7'(v >> (7 * i))}, 1'b0);
  endtask

  // random delta time: mostly short, sometimes wide or over-long
  task automatic send_delta();
    int r;
    logic [34:0] v;
    int groups;
    r = $urandom_range(0, 99);
    groups = 0;
    if (r < 50) v = 35'($urandom_range(0, 127));
    else if (r < 75) v = 35'($urandom_range(128, 16383));
    else if (r < 88) v = 35'($urandom_range(0, (1 << 21) - 1));
    else if (r < 95) v = 35'($urandom & 32'h0FFF_FFFF);
    else begin
      v = 35'({$urandom, $urandom});
      groups = 5;
    end
    if (groups == 0 && $urandom_range(0, 9) == 0) groups = $urandom_range(1, 5);
    send_quantity(v, groups);
  endtask

  // channel message body; program and pressure carry one data byte
  task automatic send_message(input logic [7:0] st, input logic [7:0] d1,
                              input logic [7:0] d2);
    send_byte(st, 1'b0);
    send_byte(d1, 1'b0);
    if (st[7:4] != TYPE_PROGRAM && st[7:4] != TYPE_PRESSURE) send_byte(d2, 1'b0);
  endtask

  // meta event body; the long form puts junk above bit 27 of the length
  task automatic send_meta(input logic [7:0] mtype, input int len, input bit long_form);
    send_byte(META_STATUS, 1'b0);
    send_byte(mtype, 1'b0);
    if (long_form) send_quantity({7'($urandom), 28'(len)}, 5);
    else send_quantity(35'(len), 0);
    repeat (len) send_byte(8'($urandom), 1'b0);
  endtask

  // 14-byte file header; a bad one has one magic byte corrupted
  task automatic send_header(input bit good, input logic [7:0] div, input logic mark);
    logic [31:0] tag;
    int pos;
    tag = "MThd";
    if (!good) begin
      pos = $urandom_range(0, 3);
      tag[8 * pos +: 8] = tag[8 * pos +: 8] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < 4; i++) send_byte(tag[8 * (3 - i) +: 8], mark && i == 0);
    repeat (9) send_byte(8'($urandom), 1'b0);
    send_byte(div, 1'b0);
    files_sent++;
  endtask

  task automatic send_track_header();
    repeat (8) send_byte(8'($urandom), 1'b0);
  endtask

  // one track event with its delta; keys and channels mostly from a small
  // pool so that note-offs usually find a start time
  task automatic random_event();
    int r;
    logic [3:0] ch;
    logic [7:0] k;
    logic [7:0] v;
    logic [7:0] st;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) begin
      ch = 4'($urandom);
      k = 8'($urandom);
    end else begin
      ch = 4'($urandom_range(0, 2));
      k = 8'($urandom_range(60, 63)) | ($urandom_range(0, 7) == 0 ? 8'h80 : 8'h00);
    end
    v = 8'($urandom);
    send_delta();
    if (r < 40) begin
      if (v[6:0] == '0) v[0] = 1'b1;
      send_message({TYPE_NOTE_ON, ch}, k, v);
    end else if (r < 62) begin
      send_message({TYPE_NOTE_OFF, ch}, k, v);
    end else if (r < 70) begin
      // note on with zero velocity acts as note off
      send_message({TYPE_NOTE_ON, ch}, k, {v[7], 7'd0});
    end else if (r < 88) begin
      // any random status but meta: controllers, program, pressure, system, notes, or no top bit
      st = 8'($urandom);
      if (st == META_STATUS) st = {TYPE_CONTROL, ch};
      send_message(st, k, v);
    end else begin
      send_meta(8'($urandom_range(1, 127)), $urandom_range(1, 6), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic end_track();
    send_delta();
    send_meta(META_END_TRACK, 0, $urandom_range(0, 3) == 0);
  endtask

  // a whole file; a few are bad headers and a few are cut short mid-track
  task automatic random_file();
    bit good;
    good = $urandom_range(0, 9) != 0;
    send_header(good, 8'($urandom), 1'b1);
    if (!good) begin
      repeat ($urandom_range(0, 12)) send_byte(8'($urandom), 1'b0);
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      send_track_header();
      repeat ($urandom_range(3, 25)) random_event();
      if ($urandom_range(0, 19) == 0) return;
      end_track();
    end
  endtask

  task automatic directed_files();
    // first file right after reset with no start mark: parser already in header
    send_header(1'b1, 8'hFF, 1'b0);
    send_track_header();
    send_quantity(0, 0);
    send_message({TYPE_NOTE_ON, 4'hF}, 8'h7F, 8'h7F);          // top channel, key, velocity
    send_quantity(127, 0);
    send_message({TYPE_NOTE_ON, 4'h0}, 8'h00, 8'h01);          // bottom key, lowest velocity
    send_quantity(128, 0);
    send_message({TYPE_NOTE_OFF, 4'hF}, 8'hFF, 8'h00);         // key byte with top bit set
    send_quantity(3, 2);
    send_message({TYPE_NOTE_ON, 4'h0}, 8'h00, 8'h80);          // zero velocity, padded delta
    send_quantity(0, 0);
    send_message({TYPE_NOTE_OFF, 4'h5}, 8'h2A, 8'hC0);         // note never started
    send_quantity(1, 0);
    send_message({TYPE_PROGRAM, 4'h3}, 8'h85, 8'h00);
    send_quantity(1, 0);
    send_message({TYPE_PRESSURE, 4'h7}, 8'h40, 8'h00);
    send_quantity(1, 0);
    send_message({TYPE_KEY_PRESSURE, 4'h2}, 8'h3C, 8'h11);
    send_quantity(1, 0);
    send_message(8'h12, 8'h34, 8'h56);                         // status without top bit
    send_quantity(2, 0);
    send_meta(META_TEXT, 3, 1'b0);
    send_quantity(0, 0);
    send_meta(META_TEMPO, 2, 1'b1);                            // length wider than 28 bits
    send_quantity(35'h7_FFFF_FFFF, 5);                         // delta wider than 28 bits
    send_message({TYPE_NOTE_ON, 4'h9}, 8'h3C, 8'h64);
    // run the tick count past 32 bits, then close the note across the wrap
    repeat (17) begin
      send_quantity(35'h0FFF_FFFF, 0);
      send_message({TYPE_PROGRAM, 4'h1}, 8'h00, 8'h00);
    end
    send_quantity(5, 0);
    send_message({TYPE_NOTE_OFF, 4'h9}, 8'h3C, 8'h00);
    send_quantity(0, 0);
    send_meta(META_END_TRACK, 0, 1'b0);
    // second track: time restarts, old start times stay in the table
    send_track_header();
    send_quantity(4, 0);
    send_message({TYPE_NOTE_OFF, 4'hF}, 8'h7F, 8'h7F);
    send_quantity(0, 0);
    send_meta(META_END_TRACK, 0, 1'b1);
    // bad magic, then bytes that must be ignored
    send_header(1'b0, 8'h60, 1'b1);
    repeat (6) send_byte(8'($urandom), 1'b0);
    // header restarted partway through, zero division
    send_byte(8'h4D, 1'b1);
    send_byte(8'h54, 1'b0);
    send_header(1'b1, 8'h00, 1'b1);
    send_track_header();
    send_quantity(9, 0);
    send_message({TYPE_NOTE_ON, 4'h0}, 8'h00, 8'h7F);
    end_track();
  endtask

  initial begin
    int target;
    rst = 1'b1;
    byte_valid = 1'b0;
    data_byte = '0;
    file_start = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    hold_req = 0;
    bytes_taken = 0;
    files_sent = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // three idling regimes: event side idle more, byte side idle more, none
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle = 30;
          recv_idle <= 52;
        end
        1: begin
          send_idle = 52;
          recv_idle <= 30;
        end
        default: begin
          send_idle = 0;
          recv_idle <= 0;
        end
      endcase
      if (p == 0) directed_files();
      if (p == 2) begin
        // long hold on the event side while notes keep coming in
        hold_req <= hold_req + 1;
        send_header(1'b1, 8'd96, 1'b1);
        send_track_header();
        repeat (50) random_event();
        end_track();
      end
      target = bytes_taken + 100;
      while (bytes_taken < target) random_file();
    end
    byte_valid <= 1'b0;

    // drain, then give any stray event time to show up
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d bytes in %0d files under three idling mixes and one long hold",
             bytes_taken, files_sent);
    $display("checked %0d events: %0d note on, %0d note off, %0d mismatches",
             events_seen, note_ons, note_offs, mismatches);
    if (mismatches == 0) begin
      $display("midi_file_note_parser verification clean");
    end else begin
      $display("midi_file_note_parser verification failed");
    end
    $finish;
  end

endmodule
